// ===== sv/lrs_pkg.sv =====
// Shared types and constants for the link reconnect supervisor.
`default_nettype none

package lrs_pkg;

    localparam int unsigned TIMER_W     = 20;
    localparam int unsigned PHASE_W     = 16;
    localparam int unsigned AGE_W       = 17;
    localparam int unsigned RETRY_W     = 4;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 17;
    localparam int unsigned BACKOFF_CAP = 4;

    localparam logic [AGE_W-1:0]   PONG_MAX  = '1;
    localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

    // Reset values of the configuration registers.
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST  = 4'd5;
    localparam logic [15:0]        BASE_DELAY_RST   = 16'd30000;
    localparam logic [15:0]        HB_INTERVAL_RST  = 16'd30000;
    localparam logic [AGE_W-1:0]   PONG_TIMEOUT_RST = 17'd60000;
    localparam logic               NET_OK_START_RST = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RETRIES  = 3'd0,
        CFG_BASE_DELAY   = 3'd1,
        CFG_HB_INTERVAL  = 3'd2,
        CFG_PONG_TIMEOUT = 3'd3,
        CFG_NET_OK_START = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_CONNECT    = 3'd0,
        EV_DISCONNECT = 3'd1,
        EV_NET_CHANGE = 3'd2,
        EV_LINK_UP    = 3'd3,
        EV_LINK_DOWN  = 3'd4,
        EV_LINK_ERROR = 3'd5,
        EV_PONG       = 3'd6,
        EV_TICK       = 3'd7
    } evt_kind_t;

    typedef enum logic [1:0] {
        ST_DISC       = 2'd0,
        ST_CONNECTING = 2'd1,
        ST_CONNECTED  = 2'd2,
        ST_RECONN     = 2'd3
    } link_state_t;

    typedef struct packed {
        evt_kind_t kind;
        logic      reachable;
    } evt_t;

    typedef struct packed {
        link_state_t link_state;
        logic        state_changed;
        logic        cmd_connect;
        logic        cmd_disconnect;
        logic        send_ping;
        logic        ready_res;
    } res_t;

    typedef struct packed {
        logic [RETRY_W-1:0] max_retries;
        logic [15:0]        base_delay;
        logic [15:0]        hb_interval;
        logic [AGE_W-1:0]   pong_timeout;
    } cfg_t;

    typedef struct packed {
        link_state_t        cur;
        logic               want;
        logic               net_ok;
        logic [RETRY_W-1:0] retry;
        logic               pend;
        logic [TIMER_W-1:0] timer;
        logic               hb_run;
        logic [PHASE_W-1:0] hb_phase;
        logic [AGE_W-1:0]   pong_age;
    } sup_state_t;

endpackage

`default_nettype wire

// ===== sv/link_reconnect_supervisor.sv =====
// Top level of the link reconnect supervisor: registers, handshake and config port.
//
// Usage:
//   evt channel: one event item (kind, reachable) per handshake; an item is
//     taken at a clock edge with evt_valid high and evt_stall low.
//   res channel: exactly one result item per event, in event order, taken at
//     an edge with res_valid high and res_stall low.
//   cfg channel: register writes by index (0 max retries, 1 base delay,
//     2 heartbeat interval, 3 pong timeout, 4 network ok at start); cfg_ready
//     is always high, unused indexes are dropped. Write only while idle.
// Path: an accepted event waits in the input register until the output
//   register is free, is stepped from there, and its result lands in the output
//   register, where res_valid rises.
// Throughput: one event per cycle while res_stall is low; the loop that sets it
//   is the update of the supervisor state register by the step logic.
// Stall: while res_stall holds a result, the input register keeps its item
//   and evt_stall rises, so at most two items wait inside the block.
// Reset: rst_n clears everything at once: link disconnected, counters zero,
//   network ok set, config registers at their reset values.
`default_nettype none

module link_reconnect_supervisor
    import lrs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  evt_valid,
    output logic                       evt_stall,
    input  wire evt_t                  evt,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output res_t                       res,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       net_start_reg;   // holds the written value; reset always restores it to 1
    sup_state_t st_reg;
    sup_state_t st_next;
    evt_t       evt_reg;
    logic       evt_valid_reg;
    res_t       res_reg;
    res_t       res_next;
    logic       res_valid_reg;
    logic       fire;
    logic       accept;

    assign cfg_ready = 1'b1;

    // step the held event when the output register is free
    assign fire      = evt_valid_reg && (!res_valid_reg || !res_stall);
    assign evt_stall = evt_valid_reg && !fire;
    assign accept    = evt_valid && !evt_stall;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_retries  <= MAX_RETRIES_RST;
            cfg_reg.base_delay   <= BASE_DELAY_RST;
            cfg_reg.hb_interval  <= HB_INTERVAL_RST;
            cfg_reg.pong_timeout <= PONG_TIMEOUT_RST;
            net_start_reg        <= NET_OK_START_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_RETRIES:  cfg_reg.max_retries  <= cfg_data[RETRY_W-1:0];
                CFG_BASE_DELAY:   cfg_reg.base_delay   <= cfg_data[15:0];
                CFG_HB_INTERVAL:  cfg_reg.hb_interval  <= cfg_data[15:0];
                CFG_PONG_TIMEOUT: cfg_reg.pong_timeout <= cfg_data[AGE_W-1:0];
                CFG_NET_OK_START: net_start_reg        <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    lrs_step u_step (
        .cur (st_reg),
        .cfg (cfg_reg),
        .evt (evt_reg),
        .nxt (st_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= '{cur: ST_DISC, want: 1'b0, net_ok: NET_OK_START_RST,
                                 retry: '0, pend: 1'b0, timer: '0, hb_run: 1'b0,
                                 hb_phase: '0, pong_age: '0};
            evt_valid_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
                st_reg <= st_next;

            if (accept)
                evt_valid_reg <= 1'b1;
            else if (fire)
                evt_valid_reg <= 1'b0;

            if (fire)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            evt_reg <= evt;
        if (fire)
            res_reg <= res_next;
    end

    // a stepped event always lands in the output register
    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("stepped event did not produce a result");

    // stall only while an event is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        evt_stall |-> evt_valid_reg)
        else $error("input stalled with nothing held");

    // a connect command always comes with the connecting state
    a_connect_state: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.cmd_connect) |-> (res.link_state == ST_CONNECTING))
        else $error("connect command outside connecting state");

    // the post-connect flag only with a connected link
    a_ready_state: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.ready_res) |-> (res.link_state == ST_CONNECTED))
        else $error("ready flag without connected state");

    // heartbeat phase rests at zero while the heartbeat is stopped
    a_hb_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.hb_run |-> (st_reg.hb_phase == '0))
        else $error("heartbeat phase moved while stopped");

endmodule

`default_nettype wire

// ===== sv/lrs_step.sv =====
// Next-state and result logic for one supervisor event.
`default_nettype none

module lrs_step
    import lrs_pkg::*;
(
    input  sup_state_t cur,
    input  cfg_t       cfg,
    input  evt_t       evt,
    output sup_state_t nxt,
    output res_t       res
);

    sup_state_t         s;
    logic               o_connect;
    logic               o_disconnect;
    logic               o_ping;
    logic               do_down;
    logic [RETRY_W-1:0] prior;
    logic [2:0]         sh;
    logic [TIMER_W-1:0] base_ext;

    always_comb
    begin
        s            = cur;
        o_connect    = 1'b0;
        o_disconnect = 1'b0;
        o_ping       = 1'b0;
        do_down      = 1'b0;
        prior        = cur.retry;
        sh           = '0;
        base_ext     = {{(TIMER_W-16){1'b0}}, cfg.base_delay};

        unique case (evt.kind)
            EV_CONNECT:
            begin
                s.want  = 1'b1;
                s.retry = '0;
                s.pend  = 1'b0;
                if (s.net_ok)
                begin
                    s.cur     = ST_CONNECTING;
                    o_connect = 1'b1;
                end
                else
                begin
                    s.cur = ST_DISC;
                end
            end
            EV_DISCONNECT:
            begin
                s.want       = 1'b0;
                s.pend       = 1'b0;
                s.hb_run     = 1'b0;
                s.hb_phase   = '0;
                o_disconnect = 1'b1;
                s.cur        = ST_DISC;
            end
            EV_NET_CHANGE:
            begin
                if (evt.reachable != s.net_ok)
                begin
                    s.net_ok = evt.reachable;
                    if (evt.reachable)
                    begin
                        if (s.want && (s.cur == ST_DISC || s.cur == ST_RECONN))
                        begin
                            s.retry   = '0;
                            s.pend    = 1'b0;
                            s.cur     = ST_CONNECTING;
                            o_connect = 1'b1;
                        end
                    end
                    else
                    begin
                        s.pend = 1'b0;
                        if (s.cur != ST_DISC)
                        begin
                            s.hb_run     = 1'b0;
                            s.hb_phase   = '0;
                            o_disconnect = 1'b1;
                            s.cur        = ST_DISC;
                        end
                    end
                end
            end
            EV_LINK_UP:
            begin
                s.retry    = '0;
                s.cur      = ST_CONNECTED;
                s.hb_run   = 1'b1;
                s.hb_phase = '0;
                s.pong_age = '0;
            end
            EV_LINK_DOWN:
            begin
                do_down = 1'b1;
            end
            EV_LINK_ERROR:
            begin
                if (s.cur == ST_CONNECTED)
                    s.cur = ST_RECONN;
            end
            EV_PONG:
            begin
                s.pong_age = '0;
            end
            EV_TICK:
            begin
                if (s.pong_age != PONG_MAX)
                    s.pong_age = s.pong_age + 1'b1;
                // reconnect countdown first; a zero count fires at once
                if (s.pend)
                begin
                    if (s.timer != '0)
                        s.timer = s.timer - 1'b1;
                    if (s.timer == '0)
                    begin
                        s.pend = 1'b0;
                        if (s.want && s.net_ok)
                        begin
                            s.cur     = ST_CONNECTING;
                            o_connect = 1'b1;
                        end
                    end
                end
                if (s.hb_run)
                begin
                    s.hb_phase = s.hb_phase + 1'b1;
                    if (s.hb_phase >= cfg.hb_interval)
                    begin
                        s.hb_phase = '0;
                        if (s.cur == ST_CONNECTED)
                        begin
                            if (s.pong_age > cfg.pong_timeout)
                                do_down = 1'b1;
                            else
                                o_ping = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // link down, from the event itself or from a missed pong
        if (do_down)
        begin
            s.hb_run   = 1'b0;
            s.hb_phase = '0;
            if (!s.want || !s.net_ok)
            begin
                s.cur = ST_DISC;
            end
            else
            begin
                prior = s.retry;
                if (s.retry != RETRY_MAX)
                    s.retry = s.retry + 1'b1;
                if (prior >= cfg.max_retries)
                begin
                    s.cur = ST_DISC;
                end
                else
                begin
                    s.cur   = ST_RECONN;
                    sh      = (prior < RETRY_W'(BACKOFF_CAP)) ? prior[2:0] : 3'(BACKOFF_CAP);
                    s.timer = base_ext << sh;
                    s.pend  = 1'b1;
                end
            end
        end

        nxt                = s;
        res.link_state     = s.cur;
        res.state_changed  = (s.cur != cur.cur);
        res.cmd_connect    = o_connect;
        res.cmd_disconnect = o_disconnect;
        res.send_ping      = o_ping;
        res.ready_res      = (evt.kind == EV_LINK_UP);
    end

endmodule

`default_nettype wire
